/* rtl/core/hall_period_speed_meter_macros.svh */
// Assertion macros used by the checker file of the hall period speed meter.
`ifndef HALL_PERIOD_SPEED_METER_MACROS_SVH
`define HALL_PERIOD_SPEED_METER_MACROS_SVH

// Property checked only while out of reset.
`define HPSM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every edge, reset included.
`define HPSM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/hpsm_pkg.sv */
// Types and constants shared by the hall period speed meter.
package hpsm_pkg;

  localparam int PERIOD_W   = 16;
  localparam int SPEED_W    = 24;
  localparam int PPR_W      = 8;
  localparam int COEFF_W    = 17;
  localparam int ELAPSED_W  = 17;
  localparam int DIVISOR_W  = PERIOD_W + PPR_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;
  localparam int PROD_W     = SPEED_W + 1 + COEFF_W + 1;

  localparam logic [COEFF_W-1:0]   Q16_ONE     = 17'h10000;
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

  localparam logic REQ_CAPTURE = 1'b0;
  localparam logic REQ_TICK    = 1'b1;

  // Register map
  localparam logic [CFG_IDX_W-1:0] CFG_PULSES_PER_REV = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_COEFF   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_PERIOD     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PERIOD     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_LIMIT    = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_FILT,
    ST_PUB
  } state_t;

  typedef struct packed {
    logic                 start;
    logic [DIVISOR_W-1:0] divisor;
  } div_ctl_t;

endpackage

/* rtl/core/hpsm_channels.sv */
// Handshake channel interfaces of the hall period speed meter.
interface hpsm_in_if;
  import hpsm_pkg::*;
  logic                valid;
  logic                ready;
  logic                req_type;
  logic [PERIOD_W-1:0] capture_count;
  modport source (output valid, req_type, capture_count, input ready);
  modport sink (input valid, req_type, capture_count, output ready);
endinterface

interface hpsm_out_if;
  import hpsm_pkg::*;
  logic                valid;
  logic                ready;
  logic                measured;
  logic [PERIOD_W-1:0] period_out;
  logic [SPEED_W-1:0]  raw_speed;
  logic [SPEED_W-1:0]  filtered_speed;
  logic                speed_valid;
  modport source (output valid, measured, period_out, raw_speed, filtered_speed,
                  speed_valid, input ready);
  modport sink (input valid, measured, period_out, raw_speed, filtered_speed,
                speed_valid, output ready);
endinterface

interface hpsm_cfg_if;
  import hpsm_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* rtl/core/hall_period_speed_meter.sv */
// Top level of the hall period speed meter.
// Hall tachometer: a request is either a 16-bit timer capture taken at a hall
// edge or a one-millisecond tick, and every request gives exactly one result
// showing the held period, the raw and filtered Q8 rpm and the valid flag. A
// tick or a capture shorter than min_period_counts goes from ST_IDLE straight
// to ST_PUB, which loads the output register. An accepted capture instead
// loads a restoring divider that produces one quotient bit per cycle, where
// QUO_W, the quotient width, is the bit length of 15360 * TIMER_HZ (34 at
// 1 MHz); then ST_DIV takes the quotient, ST_MUL multiplies, ST_FILT updates
// the filter and ST_PUB loads the output register. A capture whose divisor is
// zero skips the divider and goes through ST_MUL, ST_FILT and ST_PUB. Only one
// request is in flight: a new request is taken once the previous one has
// been placed in the output register, even while that result still waits to
// be read; while the output register is full the next result waits in front
// of it and the input stalls.
// Configuration registers may be written at any time the block is idle.
module hall_period_speed_meter #(
  parameter int unsigned TIMER_HZ = 1000000
) (
  input  logic       clk,
  input  logic       rst_n,
  hpsm_in_if.sink    in_ch,
  hpsm_out_if.source out_ch,
  hpsm_cfg_if.sink   cfg_ch
);
  import hpsm_pkg::*;

  localparam longint unsigned DIVIDEND = 64'd15360 * 64'(TIMER_HZ);
  localparam int              QUO_W    = $clog2(DIVIDEND + 1);

  // Configuration
  logic [PPR_W-1:0]    ppr_r;
  logic [PERIOD_W-1:0] timeout_r;
  logic [COEFF_W-1:0]  coeff_r;
  logic [PERIOD_W-1:0] min_per_r;
  logic [PERIOD_W-1:0] max_per_r;
  logic [PERIOD_W-1:0] limit_r;

  // Measurement state
  state_t               state_r, state_nxt;
  logic [PERIOD_W-1:0]  prev_r, prev_nxt;
  logic [PERIOD_W-1:0]  held_r, held_nxt;
  logic [SPEED_W-1:0]   raw_r, raw_nxt;
  logic [SPEED_W-1:0]   smooth_r, smooth_nxt;
  logic [ELAPSED_W-1:0] elapsed_r, elapsed_nxt;
  logic                 vflag_r, vflag_nxt;
  logic                 meas_r, meas_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;

  // Output register
  logic                out_valid_r, out_valid_nxt;
  logic                out_meas_r, out_meas_nxt;
  logic [PERIOD_W-1:0] out_period_r, out_period_nxt;
  logic [SPEED_W-1:0]  out_raw_r, out_raw_nxt;
  logic [SPEED_W-1:0]  out_filt_r, out_filt_nxt;
  logic                out_sv_r, out_sv_nxt;

  logic                 in_accept;
  logic [PERIOD_W-1:0]  period;
  logic [PERIOD_W-1:0]  per_clamp;
  logic [DIVISOR_W-1:0] divisor;
  logic [SPEED_W-1:0]   lim;
  logic [COEFF_W-1:0]   coeff_sat;
  logic [ELAPSED_W-1:0] elapsed_inc;
  logic signed [SPEED_W:0]   diff;
  logic signed [SPEED_W:0]   step;
  logic [SPEED_W:0]          smooth_sum;
  logic [SPEED_W-1:0]        raw_sat;
  div_ctl_t                  div_ctl;
  logic                      div_done;
  logic [QUO_W-1:0]          div_quo;

  hpsm_div #(
    .DIVIDEND (DIVIDEND),
    .QUO_W    (QUO_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (div_ctl),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_accept    = in_ch.valid && in_ch.ready;

  assign period      = in_ch.capture_count - prev_r;
  assign per_clamp   = (period > max_per_r) ? max_per_r : period;
  assign divisor     = DIVISOR_W'(per_clamp) * DIVISOR_W'(ppr_r);
  assign lim         = {limit_r, 8'h00};
  assign coeff_sat   = (coeff_r > Q16_ONE) ? Q16_ONE : coeff_r;
  assign elapsed_inc = (elapsed_r == ELAPSED_MAX) ? elapsed_r
                                                  : elapsed_r + ELAPSED_W'(1);
  assign raw_sat     = (div_quo > QUO_W'(lim)) ? lim : div_quo[SPEED_W-1:0];

  // Filter: smooth + floor((raw - smooth) * a / 2^16)
  assign diff       = $signed({1'b0, raw_r}) - $signed({1'b0, smooth_r});
  assign step       = prod_r[SPEED_W+16:16];
  assign smooth_sum = {1'b0, smooth_r} + step;

  always_comb begin
    state_nxt      = state_r;
    prev_nxt       = prev_r;
    held_nxt       = held_r;
    raw_nxt        = raw_r;
    smooth_nxt     = smooth_r;
    elapsed_nxt    = elapsed_r;
    vflag_nxt      = vflag_r;
    meas_nxt       = meas_r;
    prod_nxt       = prod_r;
    div_ctl.start   = 1'b0;
    div_ctl.divisor = divisor;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_meas_nxt   = out_meas_r;
    out_period_nxt = out_period_r;
    out_raw_nxt    = out_raw_r;
    out_filt_nxt   = out_filt_r;
    out_sv_nxt     = out_sv_r;
    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          meas_nxt  = 1'b0;
          state_nxt = ST_PUB;
          if (in_ch.req_type == REQ_TICK) begin
            elapsed_nxt = elapsed_inc;
            if (elapsed_inc > {1'b0, timeout_r}) begin
              smooth_nxt = '0;
              vflag_nxt  = 1'b0;
            end
          end else begin
            prev_nxt = in_ch.capture_count;
            // Drop short periods as noise
            if (period >= min_per_r) begin
              held_nxt    = per_clamp;
              elapsed_nxt = '0;
              vflag_nxt   = 1'b1;
              meas_nxt    = 1'b1;
              if (divisor == '0) begin
                raw_nxt   = lim;
                state_nxt = ST_MUL;
              end else begin
                div_ctl.start = 1'b1;
                state_nxt     = ST_DIV;
              end
            end
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          raw_nxt   = raw_sat;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        prod_nxt  = diff * $signed({1'b0, coeff_sat});
        state_nxt = ST_FILT;
      end
      ST_FILT: begin
        // Load the first sample directly
        smooth_nxt = (smooth_r == '0) ? raw_r : smooth_sum[SPEED_W-1:0];
        state_nxt  = ST_PUB;
      end
      ST_PUB: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_meas_nxt   = meas_r;
          out_period_nxt = held_r;
          out_raw_nxt    = raw_r;
          out_filt_nxt   = smooth_r;
          out_sv_nxt     = vflag_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      prev_r      <= '0;
      held_r      <= '0;
      raw_r       <= '0;
      smooth_r    <= '0;
      elapsed_r   <= '0;
      vflag_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      prev_r      <= prev_nxt;
      held_r      <= held_nxt;
      raw_r       <= raw_nxt;
      smooth_r    <= smooth_nxt;
      elapsed_r   <= elapsed_nxt;
      vflag_r     <= vflag_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    meas_r       <= meas_nxt;
    prod_r       <= prod_nxt;
    out_meas_r   <= out_meas_nxt;
    out_period_r <= out_period_nxt;
    out_raw_r    <= out_raw_nxt;
    out_filt_r   <= out_filt_nxt;
    out_sv_r     <= out_sv_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ppr_r     <= 8'd4;
      timeout_r <= 16'd500;
      coeff_r   <= 17'd6554;
      min_per_r <= 16'd100;
      max_per_r <= 16'd60000;
      limit_r   <= 16'd10000;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        CFG_PULSES_PER_REV: ppr_r     <= cfg_ch.data[PPR_W-1:0];
        CFG_TIMEOUT_TICKS:  timeout_r <= cfg_ch.data[PERIOD_W-1:0];
        CFG_FILTER_COEFF:   coeff_r   <= cfg_ch.data[COEFF_W-1:0];
        CFG_MIN_PERIOD:     min_per_r <= cfg_ch.data[PERIOD_W-1:0];
        CFG_MAX_PERIOD:     max_per_r <= cfg_ch.data[PERIOD_W-1:0];
        CFG_SPEED_LIMIT:    limit_r   <= cfg_ch.data[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.measured       = out_meas_r;
  assign out_ch.period_out     = out_period_r;
  assign out_ch.raw_speed      = out_raw_r;
  assign out_ch.filtered_speed = out_filt_r;
  assign out_ch.speed_valid    = out_sv_r;

endmodule

/* rtl/core/hpsm_div.sv */
// Bit-serial restoring divider of a constant dividend by a 24-bit divisor.
module hpsm_div #(
  parameter longint unsigned DIVIDEND = 64'd15360000000,
  parameter int              QUO_W    = 34
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  hpsm_pkg::div_ctl_t   ctl,
  output logic                 done,
  output logic [QUO_W-1:0]     quotient
);
  import hpsm_pkg::*;

  localparam int CNT_W = $clog2(QUO_W + 1);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [DIVISOR_W-1:0] rem_r, rem_nxt;
  logic [DIVISOR_W-1:0] dsr_r, dsr_nxt;
  logic [QUO_W-1:0]     quo_r, quo_nxt;

  logic [DIVISOR_W:0]   trial;
  logic [DIVISOR_W:0]   diff;
  logic                 fits;

  // One quotient bit a cycle: shift the next dividend bit into the remainder
  assign trial = {rem_r, quo_r[QUO_W-1]};
  assign diff  = trial - {1'b0, dsr_r};
  assign fits  = trial >= {1'b0, dsr_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    quo_nxt  = quo_r;
    if (ctl.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(QUO_W);
      rem_nxt  = '0;
      dsr_nxt  = ctl.divisor;
      quo_nxt  = DIVIDEND[QUO_W-1:0];
    end else if (busy_r) begin
      rem_nxt = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      quo_nxt = {quo_r[QUO_W-2:0], fits};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

/* rtl/core/hpsm_checker.sv */
// Port-level assertion checker for the hall period speed meter, with its bind.
`include "hall_period_speed_meter_macros.svh"

module hpsm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        measured,
  input logic [23:0] raw_speed,
  input logic [23:0] filtered_speed,
  input logic        speed_valid
);

  `HPSM_ASSERT_ALWAYS(a_reset_empties_output, clk, !rst_n |=> !out_valid, "result after reset")
  `HPSM_ASSERT(a_result_holds, clk, rst_n, out_valid && !out_ready |=> out_valid, "result dropped")
  `HPSM_ASSERT(a_measured_is_valid, clk, rst_n, out_valid && measured |-> speed_valid, "measured sample without valid flag")
  `HPSM_ASSERT(a_invalid_means_zero, clk, rst_n, out_valid && !speed_valid |-> filtered_speed == 24'd0, "filtered speed left after timeout")
  `HPSM_ASSERT(a_filter_stays_positive, clk, rst_n, out_valid && measured && raw_speed != 24'd0 |-> filtered_speed != 24'd0, "filter fell to zero on a positive sample")

endmodule

bind hall_period_speed_meter hpsm_checker u_hpsm_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .measured       (out_ch.measured),
  .raw_speed      (out_ch.raw_speed),
  .filtered_speed (out_ch.filtered_speed),
  .speed_valid    (out_ch.speed_valid)
);
